@@ sv/sidescan_column_projection_assert.svh @@
// Assertion macros for the side-scan column projection checker.
// Plain text macros only; no other dependencies.
`ifndef SIDESCAN_COLUMN_PROJECTION_ASSERT_SVH
`define SIDESCAN_COLUMN_PROJECTION_ASSERT_SVH

// same-cycle implication
`define SSCP_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sidescan_column_projection: assertion failed");

// next-cycle implication
`define SSCP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sidescan_column_projection: assertion failed");

`endif

@@ sv/sscp_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the side-scan column projection.
// No dependencies.
`default_nettype none

package sscp_pkg;

  // row and display limits; register widths are sized for these
  localparam int MAX_SAMPLES = 4096;
  localparam int MAX_COLUMNS = 4096;

  localparam logic [2:0] REG_SAMPLE_COUNT   = 3'd0;
  localparam logic [2:0] REG_NADIR_SPLIT    = 3'd1;
  localparam logic [2:0] REG_PORT_REACH     = 3'd2;
  localparam logic [2:0] REG_STBD_REACH     = 3'd3;
  localparam logic [2:0] REG_HEIGHT         = 3'd4;
  localparam logic [2:0] REG_GROUND_MODE    = 3'd5;
  localparam logic [2:0] REG_HALF_SPAN      = 3'd6;
  localparam logic [2:0] REG_COLUMN_TOTAL   = 3'd7;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // item travelling down the pipe next to the arithmetic
  typedef struct packed {
    logic        kind;
    logic [11:0] sample_slot;
    logic [15:0] sample_level;
    logic [11:0] column_number;
    logic        on_port;
    logic        mzero;
    logic        blank;
  } item_t;

endpackage

`default_nettype wire

@@ sv/sscp_div.sv @@
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage, with side payload.
// No dependencies.
`default_nettype none

module sscp_div #(
  parameter int NW = 38,
  parameter int DW = 14,
  parameter int QW = 24,
  parameter int PW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] in_num,
  input  logic [DW-1:0] in_den,
  input  logic [PW-1:0] in_pay,
  output logic          out_valid,
  output logic [QW-1:0] out_quo,
  output logic [PW-1:0] out_pay
);

  localparam int XW = NW + QW + DW;

  logic          st_v   [QW];
  logic [NW-1:0] st_rem [QW];
  logic [DW-1:0] st_den [QW];
  logic [QW-1:0] st_quo [QW];
  logic [PW-1:0] st_pay [QW];

  for (genvar i = 0; i < QW; i++) begin : g_step
    localparam int B = QW - 1 - i;
    logic          pv;
    logic [NW-1:0] prem;
    logic [DW-1:0] pden;
    logic [QW-1:0] pquo;
    logic [PW-1:0] ppay;
    logic [XW-1:0] cand;
    logic          take;

    if (i == 0) begin : g_first
      assign pv   = in_valid;
      assign prem = in_num;
      assign pden = in_den;
      assign pquo = '0;
      assign ppay = in_pay;
    end else begin : g_rest
      assign pv   = st_v[i-1];
      assign prem = st_rem[i-1];
      assign pden = st_den[i-1];
      assign pquo = st_quo[i-1];
      assign ppay = st_pay[i-1];
    end

    assign cand = XW'(pden) << B;
    assign take = XW'(prem) >= cand;

    always_ff @(posedge clk) begin
      if (rst) begin
        st_v[i] <= 1'b0;
      end else if (en) begin
        st_v[i] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_rem[i] <= take ? NW'(XW'(prem) - cand) : prem;
        st_den[i] <= pden;
        st_quo[i] <= take ? (pquo | (QW'(1) << B)) : pquo;
        st_pay[i] <= ppay;
      end
    end
  end

  assign out_valid = st_v[QW-1];
  assign out_quo   = st_quo[QW-1];
  assign out_pay   = st_pay[QW-1];

endmodule

`default_nettype wire

@@ sv/sscp_sqrt.sv @@
`timescale 1ns / 1ps
// Pipelined integer square root, one root bit per stage, with side payload.
// No dependencies.
`default_nettype none

module sscp_sqrt #(
  parameter int VW = 49,
  parameter int RW = 25,
  parameter int PW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [VW-1:0] in_val,
  input  logic [PW-1:0] in_pay,
  output logic          out_valid,
  output logic [RW-1:0] out_root,
  output logic [VW-1:0] out_rem,
  output logic [PW-1:0] out_pay
);

  localparam int TW = VW + RW + 2;

  logic          st_v    [RW];
  logic [VW-1:0] st_rem  [RW];
  logic [RW-1:0] st_root [RW];
  logic [PW-1:0] st_pay  [RW];

  for (genvar i = 0; i < RW; i++) begin : g_step
    localparam int B = RW - 1 - i;
    logic          pv;
    logic [VW-1:0] prem;
    logic [RW-1:0] proot;
    logic [PW-1:0] ppay;
    logic [TW-1:0] cand;
    logic          take;

    if (i == 0) begin : g_first
      assign pv    = in_valid;
      assign prem  = in_val;
      assign proot = '0;
      assign ppay  = in_pay;
    end else begin : g_rest
      assign pv    = st_v[i-1];
      assign prem  = st_rem[i-1];
      assign proot = st_root[i-1];
      assign ppay  = st_pay[i-1];
    end

    // (r + 2^b)^2 - r^2
    assign cand = (TW'(proot) << (B + 1)) + (TW'(1) << (2 * B));
    assign take = TW'(prem) >= cand;

    always_ff @(posedge clk) begin
      if (rst) begin
        st_v[i] <= 1'b0;
      end else if (en) begin
        st_v[i] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_rem[i]  <= take ? VW'(TW'(prem) - cand) : prem;
        st_root[i] <= take ? (proot | (RW'(1) << B)) : proot;
        st_pay[i]  <= ppay;
      end
    end
  end

  assign out_valid = st_v[RW-1];
  assign out_root  = st_root[RW-1];
  assign out_rem   = st_rem[RW-1];
  assign out_pay   = st_pay[RW-1];

endmodule

`default_nettype wire

@@ sv/sidescan_column_projection.sv @@
`timescale 1ns / 1ps
// Side-scan column projection: maps display columns onto one stored ping row.
// Depends on sscp_pkg, sscp_div and sscp_sqrt.
//
// Input stream (s_*): tuser[0] is the kind. A load beat writes sample_level
// to sample_slot; a query beat asks for column_number and yields one output
// beat. Output stream (m_*): column echo and pixel level in tdata, has_data
// in tuser[0].
// Configuration is to be written through cfg_we/cfg_index/cfg_data while idle;
// the block does not enforce this. Every beat enters a 74-stage pipeline:
// front end 3, magnitude divider 24, squaring 3, root 25, side select and
// offset 4, offset divider 13, slot 1, sample store read 1. One beat is
// accepted per cycle while the output is not stalled.
// Loads write the store at the same stage where queries read it, so beats
// see the row in arrival order.
// When the receiver stalls with a result held, the whole pipe holds and
// s_tready drops; nothing is lost or repeated.
// Reset (rst, synchronous) clears the valid flags and the configuration and empties the pipe; the
// sample store is not cleared and must be loaded before it is queried.
`default_nettype none

module sidescan_column_projection (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // sample_slot[11:0], sample_level[27:12], column_number[39:28]
  input  logic [0:0]  s_tuser,   // kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // column_echo[11:0], pixel_level[27:12], zero pad
  output logic [0:0]  m_tuser,   // has_data
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  import sscp_pkg::*;

  localparam int AW = $clog2(MAX_SAMPLES);
  localparam int PW = $bits(item_t);

  // configuration
  logic [12:0] sample_count, nadir_split, column_total;
  logic [23:0] port_reach, starboard_reach, height_above_bottom, display_half_span;
  logic        ground_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count        <= '0;
      nadir_split         <= '0;
      port_reach          <= '0;
      starboard_reach     <= '0;
      height_above_bottom <= '0;
      ground_mode         <= 1'b0;
      display_half_span   <= '0;
      column_total        <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SAMPLE_COUNT: sample_count        <= cfg_data[12:0];
        REG_NADIR_SPLIT:  nadir_split         <= cfg_data[12:0];
        REG_PORT_REACH:   port_reach          <= cfg_data;
        REG_STBD_REACH:   starboard_reach     <= cfg_data;
        REG_HEIGHT:       height_above_bottom <= cfg_data;
        REG_GROUND_MODE:  ground_mode         <= cfg_data[0];
        REG_HALF_SPAN:    display_half_span   <= cfg_data;
        REG_COLUMN_TOTAL: column_total        <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  // derived row geometry; the user must keep it static while items are in flight, the block does not enforce this
  logic [12:0] cnt, cols, port_n, star_n, m;
  assign cnt    = (32'(sample_count) < MAX_SAMPLES) ? sample_count : 13'(MAX_SAMPLES);
  assign cols   = (32'(column_total) < MAX_COLUMNS) ? column_total : 13'(MAX_COLUMNS);
  assign port_n = (nadir_split < cnt) ? nadir_split : cnt;
  assign star_n = cnt - port_n;
  assign m      = cols - 13'd1;

  logic [47:0] hsq;
  always_ff @(posedge clk) begin
    hsq <= ground_mode ? 48'(height_above_bottom) * 48'(height_above_bottom) : '0;
  end

  logic en;
  logic o_v;
  assign en       = !o_v || m_tready;
  assign s_tready = en;

  // stage 1: capture, fold column about centre
  logic        s1_v;
  item_t       s1_it;
  logic [12:0] s1_n;
  logic [12:0] x2;
  assign x2 = {s_tdata[39:28], 1'b0};

  always_ff @(posedge clk) begin
    if (rst) s1_v <= 1'b0;
    else if (en) s1_v <= s_tvalid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s1_it.kind          <= s_tuser[0];
      s1_it.sample_slot   <= s_tdata[11:0];
      s1_it.sample_level  <= s_tdata[27:12];
      s1_it.column_number <= s_tdata[39:28];
      s1_it.on_port       <= (x2 < m) || (x2 == m && port_reach != '0);
      s1_it.mzero         <= (m == '0);
      s1_it.blank         <= (cols == '0) || (cnt == '0) || (display_half_span == '0) ||
                             (13'(s_tdata[39:28]) >= cols);
      s1_n                <= (x2 >= m) ? x2 - m : m - x2;
    end
  end

  // stage 2: n * W
  logic        s2_v;
  item_t       s2_it;
  logic [36:0] s2_prod;
  always_ff @(posedge clk) begin
    if (rst) s2_v <= 1'b0;
    else if (en) s2_v <= s1_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s2_it   <= s1_it;
      s2_prod <= 37'(s1_n) * 37'(display_half_span);
    end
  end

  // stage 3: rounding numerator
  logic        s3_v;
  item_t       s3_it;
  logic [37:0] s3_num;
  always_ff @(posedge clk) begin
    if (rst) s3_v <= 1'b0;
    else if (en) s3_v <= s2_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s3_it  <= s2_it;
      s3_num <= {s2_prod, 1'b0} + 38'(m);
    end
  end

  logic        d1_v;
  logic [23:0] d1_q;
  logic [PW-1:0] d1_pay;
  sscp_div #(.NW(38), .DW(14), .QW(24), .PW(PW)) u_div_mag (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(s3_v), .in_num(s3_num), .in_den({m, 1'b0}), .in_pay(s3_it),
    .out_valid(d1_v), .out_quo(d1_q), .out_pay(d1_pay)
  );

  // stage 4: magnitude, zero for a single column
  logic        s4_v;
  item_t       s4_it;
  logic [23:0] s4_mag;
  item_t       d1_it;
  assign d1_it = item_t'(d1_pay);
  always_ff @(posedge clk) begin
    if (rst) s4_v <= 1'b0;
    else if (en) s4_v <= d1_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s4_it  <= d1_it;
      s4_mag <= d1_it.mzero ? '0 : d1_q;
    end
  end

  // stage 5/6: mag^2 + h^2 (h^2 is zero in slant mode, root is then exact)
  logic        s5_v, s6_v;
  item_t       s5_it, s6_it;
  logic [47:0] s5_sq;
  logic [48:0] s6_val;
  always_ff @(posedge clk) begin
    if (rst) begin
      s5_v <= 1'b0;
      s6_v <= 1'b0;
    end else if (en) begin
      s5_v <= s4_v;
      s6_v <= s5_v;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s5_it  <= s4_it;
      s5_sq  <= 48'(s4_mag) * 48'(s4_mag);
      s6_it  <= s5_it;
      s6_val <= 49'(s5_sq) + 49'(hsq);
    end
  end

  logic          q_v;
  logic [24:0]   q_root;
  logic [48:0]   q_rem;
  logic [PW-1:0] q_pay;
  sscp_sqrt #(.VW(49), .RW(25), .PW(PW)) u_sqrt (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(s6_v), .in_val(s6_val), .in_pay(s6_it),
    .out_valid(q_v), .out_root(q_root), .out_rem(q_rem), .out_pay(q_pay)
  );

  // stage 7: round root half up
  logic        s7_v;
  item_t       s7_it;
  logic [24:0] s7_slant;
  always_ff @(posedge clk) begin
    if (rst) s7_v <= 1'b0;
    else if (en) s7_v <= q_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s7_it    <= item_t'(q_pay);
      s7_slant <= (q_rem > 49'(q_root)) ? q_root + 25'd1 : q_root;
    end
  end

  // stage 8: side select and reach check
  logic        s8_v;
  item_t       s8_it;
  logic [23:0] s8_r, s8_slant;
  logic [12:0] s8_k;
  logic [23:0] r7;
  logic [12:0] k7;
  item_t       s7_chk;
  assign r7 = s7_it.on_port ? port_reach : starboard_reach;
  assign k7 = s7_it.on_port ? port_n : star_n;

  always_comb begin
    s7_chk       = s7_it;
    s7_chk.blank = s7_it.blank || (r7 == '0) || (k7 == '0) || (s7_slant > 25'(r7));
  end

  always_ff @(posedge clk) begin
    if (rst) s8_v <= 1'b0;
    else if (en) s8_v <= s7_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s8_it       <= s7_chk;
      s8_r        <= r7;
      s8_k        <= k7;
      s8_slant    <= s7_slant[23:0];
    end
  end

  // stage 9: slant * (K-1)
  logic        s9_v;
  item_t       s9_it;
  logic [23:0] s9_r;
  logic [36:0] s9_prod;
  always_ff @(posedge clk) begin
    if (rst) s9_v <= 1'b0;
    else if (en) s9_v <= s8_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s9_it   <= s8_it;
      s9_r    <= s8_r;
      s9_prod <= 37'(s8_slant) * 37'(s8_k - 13'd1);
    end
  end

  // stage 10: rounding numerator
  logic        s10_v;
  item_t       s10_it;
  logic [23:0] s10_r;
  logic [37:0] s10_num;
  always_ff @(posedge clk) begin
    if (rst) s10_v <= 1'b0;
    else if (en) s10_v <= s9_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s10_it  <= s9_it;
      s10_r   <= s9_r;
      s10_num <= {s9_prod, 1'b0} + 38'(s9_r);
    end
  end

  logic          d2_v;
  logic [12:0]   d2_q;
  logic [PW-1:0] d2_pay;
  sscp_div #(.NW(38), .DW(25), .QW(13), .PW(PW)) u_div_off (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(s10_v), .in_num(s10_num), .in_den({s10_r, 1'b0}), .in_pay(s10_it),
    .out_valid(d2_v), .out_quo(d2_q), .out_pay(d2_pay)
  );

  // stage 11: offset to slot
  logic        s11_v;
  item_t       s11_it;
  logic [12:0] s11_slot;
  item_t       d2_it;
  item_t       d2_chk;
  logic [12:0] km1, off, slot;
  assign d2_it = item_t'(d2_pay);
  assign km1   = (d2_it.on_port ? port_n : star_n) - 13'd1;
  assign off   = (d2_q > km1) ? km1 : d2_q;
  assign slot  = d2_it.on_port ? port_n - 13'd1 - off : port_n + off;

  always_comb begin
    d2_chk       = d2_it;
    d2_chk.blank = d2_it.blank || (slot >= cnt);
  end

  always_ff @(posedge clk) begin
    if (rst) s11_v <= 1'b0;
    else if (en) s11_v <= d2_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s11_it       <= d2_chk;
      s11_slot     <= slot;
    end
  end

  // stage 12: sample store, one access per beat
  logic [15:0] mem [MAX_SAMPLES];
  logic [15:0] rdata;
  logic [11:0] o_col;
  logic        o_has;
  logic        wr_ok;
  assign wr_ok = 32'(s11_it.sample_slot) < MAX_SAMPLES;

  always_ff @(posedge clk) begin
    if (en && s11_v) begin
      if (s11_it.kind == KIND_LOAD) begin
        if (wr_ok) mem[AW'(s11_it.sample_slot)] <= s11_it.sample_level;
      end else begin
        rdata <= mem[AW'(s11_slot)];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_v <= 1'b0;
    end else if (en) begin
      o_v <= s11_v && (s11_it.kind == KIND_QUERY);
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      o_col <= s11_it.column_number;
      o_has <= !s11_it.blank;
    end
  end

  assign m_tvalid = o_v;
  assign m_tdata  = {4'b0, (o_has ? rdata : 16'h0000), o_col};
  assign m_tuser  = o_has;

endmodule

`default_nettype wire

@@ sv/sscp_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks for the side-scan column projection, bound to the top.
// Depends on sidescan_column_projection_assert.svh.
`default_nettype none

module sscp_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic [0:0]  m_tuser
);

`include "sidescan_column_projection_assert.svh"

  // held result survives a stall
  `SSCP_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
  // no-data beats carry a zero pixel
  `SSCP_ASSERT_IMP(a_zero_pixel, clk, rst, m_tvalid && !m_tuser[0], m_tdata[27:12] == 16'h0000)
  // pipe freezes, so input is refused while a result is stuck
  `SSCP_ASSERT_IMP(a_stall_back, clk, rst, m_tvalid && !m_tready, !s_tready)
  // reset empties the pipe
  `SSCP_ASSERT_NEXT(a_reset_empty, clk, 1'b0, rst, !m_tvalid)

endmodule

bind sidescan_column_projection sscp_checker u_sscp_checker (.*);

`default_nettype wire
